### rtl/core/brake_light_flash_sequencer_defines.svh
// Assertion macros for the brake light flash sequencer RTL.
`ifndef BRAKE_LIGHT_FLASH_SEQUENCER_DEFINES_SVH
`define BRAKE_LIGHT_FLASH_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/blfs_pkg.sv
// Types, constants and pattern tables of the brake light flash sequencer.
package blfs_pkg;

    localparam int LEVEL_BITS = 8;

    localparam int MODE_BITS   = 4;
    localparam int TIMER_BITS  = 16;
    localparam int HOLD_BITS   = 8;
    localparam int PHASE_BITS  = 9;
    localparam int FLASH_BITS  = 6;
    localparam int PASS_BITS   = 4;

    // Input item: key_level, start_req.
    localparam int IN_FIELD_BITS = 2;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    // Result item: light_level, current_mode, pattern_busy, setup_blank, save_strobe.
    localparam int OUT_FIELD_BITS = LEVEL_BITS + MODE_BITS + 3;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BRIGHT_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGHEST_MODE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAVED_MODE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_MS    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS   = 3'd5;

    localparam logic [MODE_BITS-1:0] MODE_FLASH_FIRST = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_FLASH_LAST  = 4'd10;
    localparam logic [MODE_BITS-1:0] MODE_SWEEP       = 4'd11;
    localparam logic [PASS_BITS-1:0] SWEEP_PASSES     = 4'd9;

    typedef logic [LEVEL_BITS-1:0] t_level;

    typedef struct packed {
        logic [7:0]            dim_level;
        logic [7:0]            bright_level;
        logic [MODE_BITS-1:0]  highest_mode;
        logic [MODE_BITS-1:0]  saved_mode;
        logic [TIMER_BITS-1:0] sample_period_ms;
        logic [HOLD_BITS-1:0]  long_press_samples;
    } t_cfg;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        t_level                level;
        logic [TIMER_BITS-1:0] sample_timer;
        logic                  prev_key;
        logic [HOLD_BITS-1:0]  hold_count;
        logic                  busy;
        logic [PHASE_BITS-1:0] phase_timer;
        logic [FLASH_BITS-1:0] flash_index;
        logic                  dark_half;
        t_level                sweep_level;
        logic                  sweep_down;
        logic [PASS_BITS-1:0]  sweep_pass;
    } t_state;

    // Packed so that light_level lands in the lowest bits.
    typedef struct packed {
        logic                 save_strobe;
        logic                 setup_blank;
        logic                 pattern_busy;
        logic [MODE_BITS-1:0] current_mode;
        t_level               light_level;
    } t_result;

    // Half period of a flash mode in ticks.
    function automatic logic [PHASE_BITS-1:0] half_ticks(input logic [MODE_BITS-1:0] mode);
        logic [PHASE_BITS-1:0] ticks;
        case (mode)
            4'd1, 4'd2:  ticks = 9'd333;
            4'd3, 4'd4:  ticks = 9'd166;
            4'd5, 4'd6:  ticks = 9'd83;
            4'd7, 4'd8:  ticks = 9'd55;
            4'd9, 4'd10: ticks = 9'd41;
            default:     ticks = 9'd0;
        endcase
        return ticks;
    endfunction

    // Number of flashes of a flash mode.
    function automatic logic [FLASH_BITS-1:0] flash_total(input logic [MODE_BITS-1:0] mode);
        logic [FLASH_BITS-1:0] total;
        case (mode)
            4'd1:    total = 6'd3;
            4'd2:    total = 6'd8;
            4'd3:    total = 6'd6;
            4'd4:    total = 6'd15;
            4'd5:    total = 6'd12;
            4'd6:    total = 6'd30;
            4'd7:    total = 6'd18;
            4'd8:    total = 6'd45;
            4'd9:    total = 6'd24;
            4'd10:   total = 6'd60;
            default: total = 6'd0;
        endcase
        return total;
    endfunction

endpackage

### rtl/core/brake_light_flash_sequencer.sv
// Top level of the brake light flash sequencer: ports, registers and result stage.
//
//  Channel   Direction  Handshake                      Content
//  s_axis    in         s_axis_tvalid/s_axis_tready    one 1 ms tick: key level, start request
//  m_axis    out        m_axis_tvalid/m_axis_tready    one result per tick: level, mode, flags
//  cfg       in         i_cfg_valid/o_cfg_ready        register index and write data
//
// The state update is a single pass of logic into the state and result registers, so a
// new tick request is taken every cycle unless the output is stalled.
// Results appear in the cycle after their request is accepted.
// Reset (i_rst_n low, synchronous) loads the register defaults and clears the state and output valid.
// A stalled result holds the result register; the input keeps flowing only when that
// register is empty or being emptied in the same cycle.
module brake_light_flash_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bit 0: key_level, bit 1: start_req, rest zero
    input  logic [blfs_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // light_level, current_mode, pattern_busy, setup_blank, save_strobe, zero fill
    output logic [blfs_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [blfs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [blfs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    blfs_pkg::t_cfg    r_cfg;
    blfs_pkg::t_state  r_state;
    blfs_pkg::t_state  n_state;
    blfs_pkg::t_result n_result;
    blfs_pkg::t_result r_result;
    logic              r_out_valid;
    logic              in_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    blfs_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_key_level (s_axis_tdata[0]),
        .i_start_req (s_axis_tdata[1]),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_level          <= 8'd0;
            r_cfg.bright_level       <= 8'd255;
            r_cfg.highest_mode       <= 4'd11;
            r_cfg.saved_mode         <= 4'd0;
            r_cfg.sample_period_ms   <= 16'd1000;
            r_cfg.long_press_samples <= 8'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                blfs_pkg::CFG_DIM_LEVEL:    r_cfg.dim_level          <= i_cfg_data[7:0];
                blfs_pkg::CFG_BRIGHT_LEVEL: r_cfg.bright_level       <= i_cfg_data[7:0];
                blfs_pkg::CFG_HIGHEST_MODE: r_cfg.highest_mode       <= i_cfg_data[3:0];
                blfs_pkg::CFG_SAVED_MODE:   r_cfg.saved_mode         <= i_cfg_data[3:0];
                blfs_pkg::CFG_SAMPLE_MS:    r_cfg.sample_period_ms   <= i_cfg_data;
                blfs_pkg::CFG_LONG_PRESS:   r_cfg.long_press_samples <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = blfs_pkg::OUT_DATA_BITS'(r_result);

`include "brake_light_flash_sequencer_defines.svh"

    // Only flash and sweep modes can be playing.
    `BLFS_ASSERT_NOW(a_busy_mode, r_state.busy, (r_state.mode >= blfs_pkg::MODE_FLASH_FIRST && r_state.mode <= blfs_pkg::MODE_SWEEP), "pattern busy in a bypass mode")

    // The light is never blanked while a pattern plays.
    `BLFS_ASSERT_NOW(a_blank_idle, m_axis_tvalid, !(r_result.pattern_busy && r_result.setup_blank), "setup blank during a pattern")

    // A start request restarts the pattern counters, the sample timer and the hold count.
    `BLFS_ASSERT_NEXT(a_start_clears, in_fire && s_axis_tdata[1], (r_state.phase_timer == '0 && r_state.flash_index == '0 && r_state.sample_timer == '0 && r_state.hold_count == '0), "start request did not clear state")

endmodule

### rtl/core/blfs_step.sv
// Next-state and result logic for one millisecond tick of the sequencer.
module blfs_step (
    input  blfs_pkg::t_cfg    i_cfg,
    input  blfs_pkg::t_state  i_state,
    input  logic              i_key_level,
    input  logic              i_start_req,
    output blfs_pkg::t_state  o_state,
    output blfs_pkg::t_result o_result
);

    // Restart the pattern of the mode already placed in st.mode.
    function automatic blfs_pkg::t_state begin_pattern(input blfs_pkg::t_state st,
                                                       input blfs_pkg::t_cfg   cfg);
        blfs_pkg::t_state ns;
        ns             = st;
        ns.phase_timer = '0;
        ns.flash_index = '0;
        ns.dark_half   = 1'b0;
        ns.sweep_down  = 1'b0;
        ns.sweep_pass  = '0;
        if (st.mode >= blfs_pkg::MODE_FLASH_FIRST && st.mode <= blfs_pkg::MODE_FLASH_LAST) begin
            ns.busy  = 1'b1;
            ns.level = '1;
        end else if (st.mode == blfs_pkg::MODE_SWEEP && cfg.bright_level > cfg.dim_level) begin
            ns.busy        = 1'b1;
            ns.sweep_level = blfs_pkg::t_level'(cfg.dim_level);
            ns.level       = blfs_pkg::t_level'(cfg.dim_level);
        end else begin
            ns.busy  = 1'b0;
            ns.level = '1;
        end
        return ns;
    endfunction

    blfs_pkg::t_state          n_st;
    logic                      strobe;
    logic [blfs_pkg::MODE_BITS-1:0] next_mode;

    always_comb begin
        n_st      = i_state;
        strobe    = 1'b0;
        next_mode = i_state.mode + 4'd1;

        if (i_state.sample_timer != '1) begin
            n_st.sample_timer = i_state.sample_timer + 16'd1;
        end

        if (i_start_req) begin
            n_st.mode         = i_cfg.saved_mode;
            n_st.hold_count   = '0;
            n_st.prev_key     = 1'b0;
            n_st.sample_timer = '0;
            n_st              = begin_pattern(n_st, i_cfg);
        end else if (i_state.busy) begin
            if (i_state.mode == blfs_pkg::MODE_SWEEP) begin
                if (!i_state.sweep_down) begin
                    n_st.sweep_level = i_state.sweep_level + blfs_pkg::t_level'(1);
                    if (n_st.sweep_level == blfs_pkg::t_level'(i_cfg.bright_level)) begin
                        n_st.sweep_down = 1'b1;
                    end
                    n_st.level = n_st.sweep_level;
                end else begin
                    n_st.sweep_level = i_state.sweep_level - blfs_pkg::t_level'(1);
                    n_st.level       = n_st.sweep_level;
                    if (n_st.sweep_level == blfs_pkg::t_level'(i_cfg.dim_level)) begin
                        n_st.sweep_pass = i_state.sweep_pass + 4'd1;
                        if (n_st.sweep_pass >= blfs_pkg::SWEEP_PASSES) begin
                            n_st.busy  = 1'b0;
                            n_st.level = '1;
                        end else begin
                            n_st.sweep_down = 1'b0;
                        end
                    end
                end
            end else if (i_state.mode < blfs_pkg::MODE_FLASH_FIRST ||
                         i_state.mode > blfs_pkg::MODE_FLASH_LAST) begin
                n_st.busy  = 1'b0;
                n_st.level = '1;
            end else begin
                n_st.phase_timer = i_state.phase_timer + 9'd1;
                if (n_st.phase_timer >= blfs_pkg::half_ticks(i_state.mode)) begin
                    n_st.phase_timer = '0;
                    if (!i_state.dark_half) begin
                        n_st.dark_half = 1'b1;
                        n_st.level     = blfs_pkg::t_level'(i_cfg.dim_level);
                    end else begin
                        n_st.dark_half   = 1'b0;
                        n_st.flash_index = i_state.flash_index + 6'd1;
                        if (n_st.flash_index >= blfs_pkg::flash_total(i_state.mode)) begin
                            n_st.busy  = 1'b0;
                            n_st.level = '1;
                        end else begin
                            n_st.level = blfs_pkg::t_level'(i_cfg.bright_level);
                        end
                    end
                end
            end
        end else if (n_st.sample_timer >= i_cfg.sample_period_ms) begin
            n_st.sample_timer = '0;
            if (!i_state.prev_key && i_key_level) begin
                n_st.hold_count = '0;
            end else if (i_state.prev_key && !i_key_level) begin
                if (i_state.hold_count >= i_cfg.long_press_samples) begin
                    // Release after a long hold: next mode, save it, replay.
                    n_st.mode         = (next_mode > i_cfg.highest_mode) ? '0 : next_mode;
                    strobe            = 1'b1;
                    n_st.hold_count   = '0;
                    n_st.sample_timer = '1;
                    n_st              = begin_pattern(n_st, i_cfg);
                end
            end else if (i_key_level) begin
                if (i_state.hold_count != '1) begin
                    n_st.hold_count = i_state.hold_count + 8'd1;
                end
            end
            if (!n_st.busy && n_st.hold_count >= i_cfg.long_press_samples) begin
                n_st.level = '0;
            end
            n_st.prev_key = i_key_level;
        end
    end

    assign o_state               = n_st;
    assign o_result.light_level  = n_st.level;
    assign o_result.current_mode = n_st.mode;
    assign o_result.pattern_busy = n_st.busy;
    assign o_result.setup_blank  = !n_st.busy && (n_st.hold_count >= i_cfg.long_press_samples);
    assign o_result.save_strobe  = strobe;

endmodule
